// File: src/shp_pkg.sv
// Package with the shared types, constants and functions of the half-step homing sequencer.
`default_nettype none

package shp_pkg;

    // Item kinds as carried on the input tuser field.
    typedef enum logic [1:0] {
        MODE_TICK = 2'd0,
        MODE_TURN = 2'd1,
        MODE_ARM  = 2'd2
    } mode_t;

    localparam int ANGLE_W      = 13;
    localparam int PHASE_W      = 3;
    localparam int COILS_W      = 4;
    localparam int STEPS_W      = 2;
    localparam int IN_TDATA_W   = 16;
    localparam int OUT_TDATA_W  = 16;
    localparam int DEG_PER_REV  = 360;

    // Turn load: floor(mag * SPR / 360) as (mag * recip) >> TURN_SHIFT.
    // The shift is large enough that the result is exact for any 13-bit magnitude.
    localparam int TURN_SHIFT   = 21;

    // Homing load: ceil(rem / 360) as ((rem + 359) * REM_RECIP) >> REM_SHIFT,
    // exact for any remainder below 2^16.
    localparam int REM_Y_W      = 17;
    localparam int REM_RECIP_W  = 18;
    localparam logic [REM_RECIP_W-1:0] REM_RECIP = 18'd186414;
    localparam int REM_SHIFT    = 26;
    localparam int REM_PROD_W   = REM_Y_W + REM_RECIP_W;
    localparam int REM_CEIL_W   = REM_PROD_W - REM_SHIFT;

    // Coil drive for each of the eight half-step phases.
    function automatic logic [COILS_W-1:0] coil_pattern(input logic [PHASE_W-1:0] phase);
        logic [COILS_W-1:0] pat;
        case (phase)
            3'd0:    pat = 4'b0001;
            3'd1:    pat = 4'b0011;
            3'd2:    pat = 4'b0010;
            3'd3:    pat = 4'b0110;
            3'd4:    pat = 4'b0100;
            3'd5:    pat = 4'b1100;
            3'd6:    pat = 4'b1000;
            default: pat = 4'b1001;
        endcase
        return pat;
    endfunction

    // Phase increment: plus one forward, minus one (seven modulo eight) in reverse.
    function automatic logic [PHASE_W-1:0] phase_delta(input logic fwd);
        return fwd ? 3'd1 : 3'd7;
    endfunction

endpackage

`default_nettype wire

// File: src/shp_turn_load.sv
// Step count for a turn command: floor(STEPS_PER_REV * |angle| / 360), saturated.
`default_nettype none

module shp_turn_load
    import shp_pkg::*;
#(
    parameter int STEPS_PER_REV = 4096,
    parameter int COUNT_BITS    = 24
)
(
    input  logic signed [ANGLE_W-1:0]    angle,
    output logic                         negative,
    output logic        [COUNT_BITS-1:0] steps
);

    localparam longint unsigned TURN_RECIP =
        ((64'(STEPS_PER_REV) << TURN_SHIFT) + 64'(DEG_PER_REV - 1)) / 64'(DEG_PER_REV);
    localparam int RECIP_W = $clog2(TURN_RECIP + 1);
    localparam int PROD_W  = ANGLE_W + RECIP_W;
    localparam int RAW_W   = PROD_W - TURN_SHIFT;
    localparam int CMP_W   = (RAW_W > COUNT_BITS) ? RAW_W : COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    logic [ANGLE_W-1:0] mag;
    logic [PROD_W-1:0]  prod;
    logic [RAW_W-1:0]   raw;

    // The most negative angle has magnitude 4096, which still fits unsigned in 13 bits.
    assign negative = angle[ANGLE_W-1];
    assign mag      = negative ? ANGLE_W'(-angle) : ANGLE_W'(angle);
    assign prod     = PROD_W'(mag) * PROD_W'(TURN_RECIP);
    assign raw      = prod[PROD_W-1:TURN_SHIFT];

    always_comb
    begin
        if (CMP_W'(raw) > CMP_W'(CNT_MAX))
        begin
            steps = CNT_MAX;
        end
        else
        begin
            steps = COUNT_BITS'(raw);
        end
    end

endmodule

`default_nettype wire

// File: src/stepper_half_step_homing_core.sv
// Top level of the half-step unipolar stepper sequencer with homing run.
//
// Usage: one input channel (s_axis) carries items; the item kind is on s_axis_tuser
// (tick, turn command or arm command) and s_axis_tdata holds the turn angle and the
// home button level. Every accepted input transaction yields exactly one output
// transaction on m_axis with the held coil drive, the number of phase steps taken,
// the turning and arming flags, and the one-item magnet enable pulse.
// An accepted item is held in an input register, is processed by short logic that
// updates the motor state, and its result is loaded into the output register when
// that register is free or being emptied, so a result reaches m_axis through the
// input register and then the output register. One item per cycle is sustained
// while the receiver takes results; the single-entry input register lets one more
// transaction in while a finished result is still waiting.
// When the receiver stalls, the result holds steady and the state does not move;
// s_axis_tready drops once the input register is also full.
// The homing run tracks home_count * 360 modulo STEPS_PER_REV alongside the count,
// so the reverse turn load is one reciprocal multiply and a subtract at the end of
// the run; a turn command load is one constant multiply and a saturation.
// Reset (rst_n low, asynchronous) empties both registers and returns the motor state
// to phase zero, forward direction, no turn, no homing run and all coils off.
`default_nettype none

module stepper_half_step_homing_core
    import shp_pkg::*;
#(
    parameter int STEPS_PER_REV = 4096,
    parameter int COUNT_BITS    = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // Bits [12:0] angle (signed), [13] button_pressed, [15:14] zero.
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // Bits [1:0] mode.
    input  logic [1:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // Bits [3:0] coils, [5:4] steps_taken, [6] turning, [7] arming,
    // [8] magnet_enable, [15:9] zero.
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int REM_W = $clog2(STEPS_PER_REV);
    localparam int REM_STEP = DEG_PER_REV % STEPS_PER_REV;
    // Below this count the homing angle rounds down to zero degrees.
    localparam int HOME_ZERO_LIMIT = (STEPS_PER_REV + DEG_PER_REV - 1) / DEG_PER_REV;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // Input register.
    logic                      in_valid_reg;
    mode_t                     in_mode_reg;
    logic signed [ANGLE_W-1:0] in_angle_reg;
    logic                      in_button_reg;

    // Motor state.
    logic [PHASE_W-1:0]    phase_reg, phase_next;
    logic                  forward_reg, forward_next;
    logic [COUNT_BITS-1:0] steps_left_reg, steps_left_next;
    logic [COUNT_BITS-1:0] home_count_reg, home_count_next;
    logic [REM_W-1:0]      rem_reg, rem_next;
    logic                  turn_busy_reg, turn_busy_next;
    logic                  arm_busy_reg, arm_busy_next;
    logic [COILS_W-1:0]    coil_reg, coil_next;

    // Per-item result fields that are not part of the state.
    logic                  out_valid_reg;
    logic [STEPS_W-1:0]    taken_reg, taken_next;
    logic                  magnet_reg, magnet_next;

    logic                  advance;
    logic                  step1;
    logic [PHASE_W-1:0]    phase_mid;
    logic                  turn_negative;
    logic [COUNT_BITS-1:0] turn_steps;
    logic [REM_W:0]        rem_sum;
    logic [REM_W-1:0]      rem_stepped;
    logic                  home_short;
    logic [REM_Y_W-1:0]    home_y;
    logic [REM_PROD_W-1:0] home_prod;
    logic [REM_CEIL_W-1:0] home_ceil;
    logic [COUNT_BITS-1:0] home_steps;

    // The held item is processed when the output register is free or being emptied.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    shp_turn_load #(
        .STEPS_PER_REV (STEPS_PER_REV),
        .COUNT_BITS    (COUNT_BITS)
    ) u_turn_load (
        .angle    (in_angle_reg),
        .negative (turn_negative),
        .steps    (turn_steps)
    );

    // Running remainder of home_count * 360 modulo STEPS_PER_REV.
    assign rem_sum     = (REM_W + 1)'(rem_reg) + (REM_W + 1)'(REM_STEP);
    assign rem_stepped = (rem_sum >= (REM_W + 1)'(STEPS_PER_REV))
                         ? REM_W'(rem_sum - (REM_W + 1)'(STEPS_PER_REV))
                         : REM_W'(rem_sum);

    // Reverse turn load: floor(SPR * floor(360 h / SPR) / 360) = h - ceil(rem / 360).
    assign home_y     = REM_Y_W'(rem_reg) + REM_Y_W'(DEG_PER_REV - 1);
    assign home_prod  = REM_PROD_W'(home_y) * REM_PROD_W'(REM_RECIP);
    assign home_ceil  = home_prod[REM_PROD_W-1:REM_SHIFT];
    assign home_steps = home_count_reg - COUNT_BITS'(home_ceil);
    assign home_short = home_count_reg < COUNT_BITS'(HOME_ZERO_LIMIT);

    // The turn part of a tick steps when a counted turn still has steps left.
    assign step1     = turn_busy_reg && (steps_left_reg != '0);
    assign phase_mid = step1 ? phase_reg + phase_delta(forward_reg) : phase_reg;

    always_comb
    begin
        phase_next      = phase_reg;
        forward_next    = forward_reg;
        steps_left_next = steps_left_reg;
        home_count_next = home_count_reg;
        rem_next        = rem_reg;
        turn_busy_next  = turn_busy_reg;
        arm_busy_next   = arm_busy_reg;
        coil_next       = coil_reg;
        taken_next      = '0;
        magnet_next     = 1'b0;
        case (in_mode_reg)
            MODE_TICK:
            begin
                if (turn_busy_reg)
                begin
                    if (step1)
                    begin
                        coil_next       = coil_pattern(phase_reg);
                        phase_next      = phase_mid;
                        steps_left_next = steps_left_reg - 1'b1;
                    end
                    else
                    begin
                        turn_busy_next = 1'b0;
                    end
                end
                if (arm_busy_reg)
                begin
                    coil_next = coil_pattern(phase_mid);
                    if (in_button_reg)
                    begin
                        // Home reached: start the reverse turn and take its first step.
                        arm_busy_next   = 1'b0;
                        turn_busy_next  = 1'b1;
                        forward_next    = home_short;
                        steps_left_next = home_steps;
                        home_count_next = '0;
                        rem_next        = '0;
                        magnet_next     = 1'b1;
                        phase_next      = phase_mid + phase_delta(home_short);
                    end
                    else
                    begin
                        phase_next = phase_mid + phase_delta(forward_reg);
                        if (home_count_reg != CNT_MAX)
                        begin
                            home_count_next = home_count_reg + 1'b1;
                            rem_next        = rem_stepped;
                        end
                    end
                end
                taken_next = STEPS_W'(step1) + STEPS_W'(arm_busy_reg);
            end
            MODE_TURN:
            begin
                forward_next    = !turn_negative;
                steps_left_next = turn_steps;
                turn_busy_next  = 1'b1;
            end
            MODE_ARM:
            begin
                arm_busy_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_mode_reg   <= mode_t'(s_axis_tuser);
            in_angle_reg  <= s_axis_tdata[ANGLE_W-1:0];
            in_button_reg <= s_axis_tdata[ANGLE_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= '0;
            forward_reg    <= 1'b1;
            steps_left_reg <= '0;
            home_count_reg <= '0;
            rem_reg        <= '0;
            turn_busy_reg  <= 1'b0;
            arm_busy_reg   <= 1'b0;
            coil_reg       <= '0;
            out_valid_reg  <= 1'b0;
            taken_reg      <= '0;
            magnet_reg     <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg      <= phase_next;
                forward_reg    <= forward_next;
                steps_left_reg <= steps_left_next;
                home_count_reg <= home_count_next;
                rem_reg        <= rem_next;
                turn_busy_reg  <= turn_busy_next;
                arm_busy_reg   <= arm_busy_next;
                coil_reg       <= coil_next;
                taken_reg      <= taken_next;
                magnet_reg     <= magnet_next;
                out_valid_reg  <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The state registers change only together with the output register, so the
    // held state is the state after the item being shown.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, magnet_reg, arm_busy_reg, turn_busy_reg, taken_reg, coil_reg};

endmodule

`default_nettype wire

// File: src/shp_checker.sv
// Port-level checker for the half-step homing sequencer, bound to the top level.
`default_nettype none

module shp_checker
    import shp_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result stays offered and unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // The end of a homing run starts a reverse turn, ends arming and takes a step.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[8]
        |-> m_axis_tdata[6] && !m_axis_tdata[7] && (m_axis_tdata[5:4] != 2'd0))
        else $error("magnet pulse without homing end state");

    // Two steps in one tick only happen while arming or at the end of a homing run.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[5:4] == 2'd2) |-> m_axis_tdata[7] || m_axis_tdata[8])
        else $error("double step outside homing");

    // At most two steps per item, and a step always leaves a coil energized.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[5:4] != 2'd0)
        |-> (m_axis_tdata[5:4] != 2'd3) && (m_axis_tdata[3:0] != 4'd0))
        else $error("bad step count or coils off after a step");

endmodule

bind stepper_half_step_homing_core shp_checker u_shp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
